@@ design/pixel_row_run_rectangles_assert.svh @@
// Assertion macros shared by the pixel row run rectangles RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PIXEL_ROW_RUN_RECTANGLES_ASSERT_SVH
`define PIXEL_ROW_RUN_RECTANGLES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIXRR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("pixrr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIXRR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("pixrr assertion failed");

`endif

@@ design/pixrr_pkg.sv @@
// Package for the pixel row run rectangles block: widths, limits, queue size
// and the command and queue entry types. Depends on nothing.
`default_nettype none

package pixrr_pkg;

	localparam int unsigned COLOR_W  = 8;
	localparam int unsigned IN_COL_W = 12;
	localparam int unsigned COL_W    = 13;
	localparam int unsigned TOP_W    = 12;
	localparam int unsigned HGT_W    = 13;
	localparam int unsigned BOT_W    = 13;

	// Longest row in pixels; the column stops at the last start column plus this less one
	localparam int unsigned MAX_ROW   = 4096;
	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(4095 + MAX_ROW - 1);
	localparam logic [BOT_W-1:0] BOTTOM_MAX = {BOT_W{1'b1}};

	// Command queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [COL_W-1:0]   left;
		logic [COL_W-1:0]   right;
	} cmd_t;

	// One queue entry holds every command that a single pixel causes
	typedef struct packed {
		logic [TOP_W-1:0] top;
		logic [BOT_W-1:0] bottom;
		logic             a_vld;
		cmd_t             a;
		logic             b_vld;
		cmd_t             b;
	} entry_t;

endpackage

`default_nettype wire

@@ design/pixrr_front.sv @@
// Front end: accepts pixels, tracks the open run and row header, and builds
// one queue entry per pixel that causes a command. Depends on pixrr_pkg.
`default_nettype none

module pixrr_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pixrr_pkg::COLOR_W-1:0]  pixel_color,
	input  wire logic                           row_first,
	input  wire logic                           row_final,
	input  wire logic [pixrr_pkg::IN_COL_W-1:0] start_column,
	input  wire logic [pixrr_pkg::TOP_W-1:0]    top_line,
	input  wire logic [pixrr_pkg::HGT_W-1:0]    row_height,
	input  wire logic                           draw_zero,
	input  wire logic                           q_full,
	output logic                                push,
	output pixrr_pkg::entry_t                   push_entry
);
	import pixrr_pkg::*;

	logic [COLOR_W-1:0] run_color_q;
	logic [COL_W-1:0]   run_start_q;
	logic [COL_W-1:0]   column_now_q;
	logic [TOP_W-1:0]   line_top_q;
	logic [BOT_W-1:0]   line_bottom_q;
	logic               keep_zero_q;

	logic [COLOR_W-1:0] color_d;
	logic [COL_W-1:0]   start_d;
	logic [COL_W-1:0]   column_d;
	logic [TOP_W-1:0]   top_d;
	logic [BOT_W-1:0]   bottom_d;
	logic               keep_d;
	logic [HGT_W-1:0]   height;
	logic [BOT_W:0]     bottom_sum;
	logic [COL_W-1:0]   column_inc;
	logic               change;
	logic               accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Work out the header, the next column and the run break
	always_comb begin
		height     = (row_height == '0) ? HGT_W'(1) : row_height;
		bottom_sum = {2'b00, top_line} + {1'b0, height} - (BOT_W+1)'(1);
		column_inc = (column_now_q < COL_LIMIT) ? column_now_q + COL_W'(1) : column_now_q;
		change     = !row_first && (pixel_color != run_color_q);

		if (row_first) begin
			top_d    = top_line;
			bottom_d = (bottom_sum > {1'b0, BOTTOM_MAX}) ? BOTTOM_MAX : bottom_sum[BOT_W-1:0];
			keep_d   = draw_zero;
			column_d = {1'b0, start_column};
			color_d  = pixel_color;
			start_d  = {1'b0, start_column};
		end else begin
			top_d    = line_top_q;
			bottom_d = line_bottom_q;
			keep_d   = keep_zero_q;
			column_d = column_inc;
			color_d  = change ? pixel_color : run_color_q;
			start_d  = change ? column_inc : run_start_q;
		end
	end

	// Build the entry: the finished run first, the open run at row end second
	always_comb begin
		push_entry.top      = top_d;
		push_entry.bottom   = bottom_d;
		push_entry.a_vld    = change && (keep_zero_q || (run_color_q != '0));
		push_entry.a.color  = run_color_q;
		push_entry.a.left   = run_start_q;
		push_entry.a.right  = (column_inc > run_start_q) ? column_inc - COL_W'(1) : run_start_q;
		push_entry.b_vld    = row_final && (keep_d || (color_d != '0));
		push_entry.b.color  = color_d;
		push_entry.b.left   = start_d;
		push_entry.b.right  = column_d;
		push = accept && (push_entry.a_vld || push_entry.b_vld);
	end

	// Advance the run state on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_color_q   <= '0;
			run_start_q   <= '0;
			column_now_q  <= '0;
			line_top_q    <= '0;
			line_bottom_q <= '0;
			keep_zero_q   <= 1'b0;
		end else if (accept) begin
			run_color_q   <= color_d;
			run_start_q   <= start_d;
			column_now_q  <= column_d;
			line_top_q    <= top_d;
			line_bottom_q <= bottom_d;
			keep_zero_q   <= keep_d;
		end
	end

endmodule

`default_nettype wire

@@ design/pixrr_queue.sv @@
// Short command queue that decouples the pixel front end from the output
// back end. Depends on pixrr_pkg and the assertion macro header.
`default_nettype none

`include "pixel_row_run_rectangles_assert.svh"

module pixrr_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire pixrr_pkg::entry_t push_entry,
	output logic             full,
	output logic             head_valid,
	output pixrr_pkg::entry_t head_entry,
	input  wire logic        pop
);
	import pixrr_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// Store entries; no reset on payload
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop && head_valid) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(push && !full) - (QAW+1)'(pop && head_valid);
		end
	end

	`PIXRR_ASSERT_IMP(a_q_count_bound, clk, arst_n, 1'b1, count_q <= (QAW+1)'(QDEPTH))
	`PIXRR_ASSERT_IMP(a_q_pop_nonempty, clk, arst_n, pop, head_valid)

endmodule

`default_nettype wire

@@ design/pixrr_back.sv @@
// Back end: pops queue entries and drives the rectangle commands through an
// output register, one or two per entry. Depends on pixrr_pkg and the macros.
`default_nettype none

`include "pixel_row_run_rectangles_assert.svh"

module pixrr_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire pixrr_pkg::entry_t            head_entry,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [pixrr_pkg::COLOR_W-1:0]     fill_color,
	output logic [pixrr_pkg::COL_W-1:0]       left_x,
	output logic [pixrr_pkg::TOP_W-1:0]       top_y,
	output logic [pixrr_pkg::COL_W-1:0]       right_x,
	output logic [pixrr_pkg::BOT_W-1:0]       bottom_y,
	output logic                              last_of_item
);
	import pixrr_pkg::*;

	logic             out_valid_q;
	cmd_t             out_cmd_q;
	logic [TOP_W-1:0] out_top_q;
	logic [BOT_W-1:0] out_bottom_q;
	logic             out_last_q;
	logic             pend_q;
	cmd_t             pend_cmd_q;
	logic             free;

	assign free = !out_valid_q || !out_stall;
	assign pop  = free && !pend_q && head_valid;

	// Control: output valid and the pending second command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (head_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= head_entry.a_vld && head_entry.b_vld;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: load the next command when the output register frees up
	always_ff @(posedge clk) begin
		if (free) begin
			if (pend_q) begin
				out_cmd_q  <= pend_cmd_q;
				out_last_q <= 1'b1;
			end else if (head_valid) begin
				out_top_q    <= head_entry.top;
				out_bottom_q <= head_entry.bottom;
				pend_cmd_q   <= head_entry.b;
				if (head_entry.a_vld) begin
					out_cmd_q  <= head_entry.a;
					out_last_q <= !head_entry.b_vld;
				end else begin
					out_cmd_q  <= head_entry.b;
					out_last_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign fill_color   = out_cmd_q.color;
	assign left_x       = out_cmd_q.left;
	assign right_x      = out_cmd_q.right;
	assign top_y        = out_top_q;
	assign bottom_y     = out_bottom_q;
	assign last_of_item = out_last_q;

	`PIXRR_ASSERT_IMP(a_back_pend_shown, clk, arst_n, pend_q, out_valid_q && !out_last_q)
	`PIXRR_ASSERT_NXT(a_back_pend_next, clk, arst_n, pend_q && !out_stall, out_valid_q && out_last_q)

endmodule

`default_nettype wire

@@ design/pixel_row_run_rectangles.sv @@
// Pixel row run rectangles: turns rows of colour indices into filled
// rectangle commands, one per run of equal colour. Top level.
//
// Input channel (in_valid / in_stall): one pixel per transaction; the
// row_first pixel also carries start column, top line, height and draw-zero.
// A transaction is taken on a rising edge with valid high and stall low.
// Output channel (out_valid / out_stall): one rectangle command per
// transaction; last_of_item marks the final command caused by a pixel.
// A pixel is taken every cycle while the four-entry command queue has room.
// A pixel that causes a command is written into the queue, then loaded into
// the output register when it is free; a pixel that both closes a run and
// ends its row yields two commands as consecutive output transactions, so
// the output port sets the sustained rate then.
// When the receiver stalls, the output register holds its command and the
// queue fills; with the queue full in_stall rises until a command drains.
// Asynchronous reset clears the run state to a colour-zero row at line zero,
// column zero, height one, and empties the queue and output register.
// Depends on pixrr_pkg, pixrr_front, pixrr_queue and pixrr_back.
`default_nettype none

module pixel_row_run_rectangles (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pixrr_pkg::COLOR_W-1:0]  pixel_color,
	input  wire logic                           row_first,
	input  wire logic                           row_final,
	input  wire logic [pixrr_pkg::IN_COL_W-1:0] start_column,
	input  wire logic [pixrr_pkg::TOP_W-1:0]    top_line,
	input  wire logic [pixrr_pkg::HGT_W-1:0]    row_height,
	input  wire logic                           draw_zero,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [pixrr_pkg::COLOR_W-1:0]       fill_color,
	output logic [pixrr_pkg::COL_W-1:0]         left_x,
	output logic [pixrr_pkg::TOP_W-1:0]         top_y,
	output logic [pixrr_pkg::COL_W-1:0]         right_x,
	output logic [pixrr_pkg::BOT_W-1:0]         bottom_y,
	output logic                                last_of_item
);
	import pixrr_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	// Classify pixels and build queue entries
	pixrr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_color  (pixel_color),
		.row_first    (row_first),
		.row_final    (row_final),
		.start_column (start_column),
		.top_line     (top_line),
		.row_height   (row_height),
		.draw_zero    (draw_zero),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	// Buffer entries between the two sides
	pixrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// Drive commands out
	pixrr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fill_color   (fill_color),
		.left_x       (left_x),
		.top_y        (top_y),
		.right_x      (right_x),
		.bottom_y     (bottom_y),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire

@@ sim/pixrr_rect_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the pixel row run rectangles testbench: follows the colour runs
// of each row, queues the rectangle commands they close and checks them in order.
// Depends on pixrr_pkg for widths and limits.
package pixrr_rect_scoreboard_pkg;
	import pixrr_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [COLOR_W-1:0]  color;
		logic                row_first;
		logic                row_final;
		logic [IN_COL_W-1:0] start_column;
		logic [TOP_W-1:0]    top_line;
		logic [HGT_W-1:0]    row_height;
		logic                draw_zero;
	} pixel_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [COL_W-1:0]   left;
		logic [TOP_W-1:0]   top;
		logic [COL_W-1:0]   right;
		logic [BOT_W-1:0]   bottom;
		logic               last;
	} rect_t;

	class rect_scoreboard;
		// Open run and row header, as the block holds them
		logic [COLOR_W-1:0] run_color;
		logic [COL_W-1:0]   run_left;
		logic [COL_W-1:0]   column;
		logic [TOP_W-1:0]   row_top;
		logic [BOT_W-1:0]   row_bottom;
		logic               keep_zero;
		rect_t              rects_due[$];
		int                 pixels_seen;
		int                 rects_checked;
		int                 fails;

		function new();
			run_color     = '0;
			run_left      = '0;
			column        = '0;
			row_top       = '0;
			row_bottom    = '0;
			keep_zero     = 1'b0;
			pixels_seen   = 0;
			rects_checked = 0;
			fails         = 0;
		endfunction

		function rect_t make_rect(logic [COLOR_W-1:0] colour, logic [COL_W-1:0] left,
				logic [COL_W-1:0] right);
			rect_t r;
			r.color  = colour;
			r.left   = left;
			r.top    = row_top;
			r.right  = right;
			r.bottom = row_bottom;
			r.last   = 1'b0;
			return r;
		endfunction

		// Advance the run state by one accepted pixel and queue the commands it closes
		function void note_pixel(pixel_t px);
			rect_t made[$];
			int    height;
			int    bottom;
			if (px.row_first) begin
				// a header drops whatever run was still open
				height     = (px.row_height == '0) ? 1 : int'(px.row_height);
				row_top    = px.top_line;
				bottom     = int'(px.top_line) + height - 1;
				row_bottom = (bottom > int'(BOTTOM_MAX)) ? BOTTOM_MAX : BOT_W'(bottom);
				keep_zero  = px.draw_zero;
				column     = COL_W'(px.start_column);
				run_color  = px.color;
				run_left   = column;
			end else begin
				// hold the column once it reaches the end of the longest row
				if (column < COL_LIMIT)
					column = column + 1'b1;
				if (px.color != run_color) begin
					if (keep_zero || run_color != '0)
						made.push_back(make_rect(run_color, run_left,
							(column > run_left) ? column - 1'b1 : run_left));
					run_color = px.color;
					run_left  = column;
				end
			end
			if (px.row_final && (keep_zero || run_color != '0))
				made.push_back(make_rect(run_color, run_left, column));
			if (made.size() > 0)
				made[made.size() - 1].last = 1'b1;
			foreach (made[i])
				rects_due.push_back(made[i]);
			pixels_seen++;
		endfunction

		// Compare one accepted command with the oldest one due
		function void check_rect(rect_t got);
			rect_t want;
			if (rects_due.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("unexpected command: colour %0d left %0d top %0d right %0d bottom %0d last %0b",
						got.color, got.left, got.top, got.right, got.bottom, got.last);
				return;
			end
			want = rects_due.pop_front();
			rects_checked++;
			if (got.color !== want.color || got.left !== want.left || got.top !== want.top ||
					got.right !== want.right || got.bottom !== want.bottom ||
					got.last !== want.last) begin
				fails++;
				if (fails <= MAX_REPORTS) begin
					$display("command %0d mismatch", rects_checked);
					$display("  expected colour %0d left %0d top %0d right %0d bottom %0d last %0b",
						want.color, want.left, want.top, want.right, want.bottom, want.last);
					$display("  actual   colour %0d left %0d top %0d right %0d bottom %0d last %0b",
						got.color, got.left, got.top, got.right, got.bottom, got.last);
				end
			end
		endfunction
	endclass

endpackage

@@ sim/pixel_row_run_rectangles_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for pixel_row_run_rectangles: drives rows of pixels, stalls the
// command side at random and checks every command. Depends on pixrr_pkg and the scoreboard.
module pixel_row_run_rectangles_tb;
	import pixrr_pkg::*;
	import pixrr_rect_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PIXELS = 1300;
	localparam int SETTLE_CYCLES = 12;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [COLOR_W-1:0]  pixel_color = '0;
	logic                row_first = 1'b0;
	logic                row_final = 1'b0;
	logic [IN_COL_W-1:0] start_column = '0;
	logic [TOP_W-1:0]    top_line = '0;
	logic [HGT_W-1:0]    row_height = '0;
	logic                draw_zero = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [COLOR_W-1:0]  fill_color;
	logic [COL_W-1:0]    left_x;
	logic [TOP_W-1:0]    top_y;
	logic [COL_W-1:0]    right_x;
	logic [BOT_W-1:0]    bottom_y;
	logic                last_of_item;

	rect_scoreboard rect_board = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pixels_sent = 0;
	int cycles = 0;

	always #2 clk = ~clk;

	pixel_row_run_rectangles uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_color  (pixel_color),
		.row_first    (row_first),
		.row_final    (row_final),
		.start_column (start_column),
		.top_line     (top_line),
		.row_height   (row_height),
		.draw_zero    (draw_zero),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fill_color   (fill_color),
		.left_x       (left_x),
		.top_y        (top_y),
		.right_x      (right_x),
		.bottom_y     (bottom_y),
		.last_of_item (last_of_item)
	);

	// Stall the command side at the current rate
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Note accepted pixels, then check accepted commands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				rect_board.note_pixel('{pixel_color, row_first, row_final, start_column,
					top_line, row_height, draw_zero});
			if (out_valid && !out_stall)
				rect_board.check_rect('{fill_color, left_x, top_y, right_x, bottom_y,
					last_of_item});
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d commands still due", cycles,
				rect_board.rects_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one pixel, idling cycle by cycle at the current rate, and hold it until taken
	task automatic send_pixel(pixel_t px);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pixel_color  <= px.color;
		row_first    <= px.row_first;
		row_final    <= px.row_final;
		start_column <= px.start_column;
		top_line     <= px.top_line;
		row_height   <= px.row_height;
		draw_zero    <= px.draw_zero;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_fields(logic [COLOR_W-1:0] colour, logic first, logic last_px,
			logic [IN_COL_W-1:0] col, logic [TOP_W-1:0] top, logic [HGT_W-1:0] height,
			logic zero_on);
		send_pixel('{colour, first, last_px, col, top, height, zero_on});
	endtask

	// Mostly short heights, now and then any 13-bit value or an edge value
	function automatic logic [HGT_W-1:0] pick_height();
		case ($urandom_range(0, 9))
			0, 1: return HGT_W'($urandom_range(0, 8191));
			2: return ($urandom_range(0, 1) == 1) ? HGT_W'(4096) : HGT_W'(8191);
			3: return '0;
			default: return HGT_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Favour zero and a small palette so that runs grow and zero runs occur
	function automatic logic [COLOR_W-1:0] pick_colour();
		case ($urandom_range(0, 3))
			0: return '0;
			1, 2: return COLOR_W'($urandom_range(1, 3));
			default: return COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t noise_pixel();
		pixel_t px;
		px.color        = COLOR_W'($urandom_range(0, 255));
		px.row_first    = 1'($urandom_range(0, 1));
		px.row_final    = 1'($urandom_range(0, 1));
		px.start_column = IN_COL_W'($urandom_range(0, 4095));
		px.top_line     = TOP_W'($urandom_range(0, 4095));
		px.row_height   = HGT_W'($urandom_range(0, 8191));
		px.draw_zero    = 1'($urandom_range(0, 1));
		return px;
	endfunction

	// Send a row of random runs; the header and the closing pixel are optional
	task automatic send_row(int len, bit with_header, bit with_end);
		pixel_t             px;
		logic [COLOR_W-1:0] colour;
		colour = pick_colour();
		for (int i = 0; i < len; i++) begin
			px = noise_pixel();
			if ($urandom_range(0, 2) == 0)
				colour = pick_colour();
			px.color     = colour;
			px.row_first = with_header && i == 0;
			px.row_final = with_end && i == len - 1;
			if (px.row_first)
				px.row_height = pick_height();
			send_pixel(px);
		end
	endtask

	task automatic random_phase(int pixels);
		int stop_at;
		stop_at = pixels_sent + pixels;
		while (pixels_sent < stop_at) begin
			case ($urandom_range(0, 19))
				0: send_pixel(noise_pixel());
				1: send_row($urandom_range(1, 6), 1'b1, 1'b0);
				2: send_row($urandom_range(1, 6), 1'b0, 1'b1);
				3: send_row($urandom_range(13, 40), 1'b1, 1'b1);
				default: send_row($urandom_range(1, 12), 1'b1, 1'b1);
			endcase
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 82;
		// pixels with no header after reset continue a colour-zero row
		send_fields(8'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd5, 1'b0, 1'b1, '0, '0, '0, 1'b0);
		// single-pixel row at the far corner
		send_fields(8'd255, 1'b1, 1'b1, 12'd4095, 12'd4095, 13'd4096, 1'b0);
		// zero height, and a pixel that both closes a run and ends the row
		send_fields(8'd1, 1'b1, 1'b0, 12'd0, 12'd0, 13'd0, 1'b1);
		send_fields(8'd0, 1'b0, 1'b1, '0, '0, '0, 1'b0);
		// bottom beyond the last line, zero run dropped
		send_fields(8'd7, 1'b1, 1'b0, 12'd100, 12'd4095, 13'd8191, 1'b0);
		send_fields(8'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd9, 1'b0, 1'b1, '0, '0, '0, 1'b0);
		// a header in mid-row drops the open run
		send_fields(8'd3, 1'b1, 1'b0, 12'd10, 12'd20, 13'd3, 1'b0);
		send_fields(8'd3, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd4, 1'b1, 1'b0, 12'd20, 12'd21, 13'd1, 1'b0);
		send_fields(8'd4, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd200, 1'b0, 1'b1, '0, '0, '0, 1'b0);
		// zero runs kept when draw-zero is set, dropped otherwise
		send_fields(8'd0, 1'b1, 1'b0, 12'd50, 12'd1, 13'd2, 1'b1);
		send_fields(8'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
		send_fields(8'd0, 1'b0, 1'b1, '0, '0, '0, 1'b0);
		send_fields(8'd0, 1'b1, 1'b0, 12'd60, 12'd2, 13'd1, 1'b0);
		send_fields(8'd0, 1'b0, 1'b1, '0, '0, '0, 1'b0);

		random_phase(RANDOM_PIXELS / 3);
		send_idle_pct = 82;
		recv_idle_pct = 31;
		random_phase(RANDOM_PIXELS / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(RANDOM_PIXELS / 3);
		in_valid <= 1'b0;

		// drain, then give any stray command time to show
		while (rect_board.rects_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d pixels: directed rows, random rows and broken rows.",
			rect_board.pixels_seen);
		$display("Checked %0d rectangle commands under three stall mixes, %0d failures.",
			rect_board.rects_checked, rect_board.fails);
		if (rect_board.fails == 0 && rect_board.rects_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
